/* design/pte_pkg.sv */
package pte_pkg;

  localparam int GATES_DEF = 256;

  localparam int VAL_W      = 32;
  localparam int RATE_W     = 16;
  localparam int MODE_W     = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 56;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [RATE_W-1:0] DECAY_RATE_RST = 16'd13107;
  localparam logic [VAL_W-1:0]  LEVEL_MIN_RST  = 32'h0000_0000;
  localparam logic [VAL_W-1:0]  LEVEL_MAX_RST  = 32'hFFFF_FFFF;
  localparam logic [VAL_W-1:0]  LEVEL_INIT_RST = 32'h0001_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT    = 3'd0,
    MODE_EVAP    = 3'd1,
    MODE_CLAMP   = 3'd2,
    MODE_DEPOSIT = 3'd3,
    MODE_READ    = 3'd4
  } mode_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DECAY_RATE = 2'd0,
    CFG_LEVEL_MIN  = 2'd1,
    CFG_LEVEL_MAX  = 2'd2,
    CFG_LEVEL_INIT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic load;       // latch the accepted item
    logic rd_en;      // table read
    logic sweep;      // read belongs to a whole-table sweep
    logic div_start;
    logic div_step;
    logic cap_p;      // capture the read entry
    logic dep_wr;     // write back deposit sum
    logic res_load;   // load the result register
  } pte_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic gate_ok;
    logic out_busy;
  } pte_sts_t;

endpackage

/* design/pheromone_table_engine.sv */
// Pheromone table engine: 2*GATES unsigned Q16.16 entries (two per gate) in one
// memory with a registered read port and one write port. One transaction runs one
// operation picked by s_tuser: init, evaporate, clamp, deposit or read; modes 5..7
// are consumed and produce no result. Init, evaporate and clamp sweep the table
// through a three-stage read/multiply/write pipeline, one entry per cycle. Deposit
// runs the 32-step restoring divider that forms (weight << 32) / score. One
// transaction is in flight at a time; the result sits in an output register so
// the next transaction can be taken while it waits. There is no clearing pass
// after reset: entries are undefined until an init has run, and reading them
// before that gives undefined values. Configuration writes must be issued only
// while the engine is idle.
module pheromone_table_engine
  import pte_pkg::*;
#(
  parameter int GATES = GATES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VAL_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // gate[7:0], choice[8], weight[16:9], score[48:17]
  input  logic [MODE_W-1:0]     s_tuser,  // mode[2:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VAL_W-1:0]      m_tdata,  // value[31:0]
  output logic [MODE_W-1:0]     m_tuser   // op_done[2:0]
);

  localparam int AW = $clog2(2 * GATES);

  pte_cmd_t      cmd;
  pte_sts_t      sts;
  logic [AW-1:0] sweep_addr;

  pte_ctrl #(.GATES(GATES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_mode     (s_tuser),
    .sts        (sts),
    .cmd        (cmd),
    .sweep_addr (sweep_addr)
  );

  pte_dp #(.GATES(GATES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .s_tdata    (s_tdata),
    .s_mode     (s_tuser),
    .cmd        (cmd),
    .sweep_addr (sweep_addr),
    .sts        (sts),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

/* design/pte_ctrl.sv */
module pte_ctrl
  import pte_pkg::*;
#(
  parameter int GATES = GATES_DEF,
  localparam int AW = $clog2(2 * GATES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [MODE_W-1:0] s_mode,
  input  pte_sts_t          sts,
  output pte_cmd_t          cmd,
  output logic [AW-1:0]     sweep_addr
);

  localparam int ENTRIES = 2 * GATES;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SWEEP = 8'b0000_0010,
    ST_DRAIN = 8'b0000_0100,
    ST_RD    = 8'b0000_1000,
    ST_RDW   = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_WB    = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t                 state, state_next;
  logic [AW-1:0]          cnt;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [MODE_W-1:0]      mode;

  assign sweep_addr = cnt;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (s_mode) inside
            MODE_INIT, MODE_EVAP, MODE_CLAMP: state_next = ST_SWEEP;
            MODE_DEPOSIT, MODE_READ:          state_next = ST_RD;
            default:                          state_next = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd.rd_en = 1'b1;
        cmd.sweep = 1'b1;
        if (cnt == LAST_ADDR) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_next = ST_DONE;
      end
      ST_RD: begin
        if (sts.gate_ok) begin
          cmd.rd_en     = 1'b1;
          cmd.div_start = 1'b1;
          state_next    = ST_RDW;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RDW: begin
        cmd.cap_p = 1'b1;
        if (mode == MODE_DEPOSIT) state_next = ST_DIV;
        else                      state_next = ST_DONE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) state_next = ST_WB;
      end
      ST_WB: begin
        cmd.dep_wr = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cnt     <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      cnt     <= (state == ST_SWEEP) ? cnt + AW'(1) : '0;
      div_cnt <= (state == ST_DIV) ? div_cnt + DIV_CNT_W'(1) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mode <= s_mode;
  end

  a_res_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !sts.out_busy)
    else $error("result loaded while output register still occupied");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !sts.pipe_busy)
    else $error("ready for a new transaction while sweep pipeline busy");

  a_div_full_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WB) |-> ($past(div_cnt) == DIV_LAST))
    else $error("deposit write-back before divider finished");

endmodule

/* design/pte_dp.sv */
module pte_dp
  import pte_pkg::*;
#(
  parameter int GATES = GATES_DEF,
  localparam int AW = $clog2(2 * GATES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VAL_W-1:0]      cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [MODE_W-1:0]     s_mode,
  input  pte_cmd_t              cmd,
  input  logic [AW-1:0]         sweep_addr,
  output pte_sts_t              sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [VAL_W-1:0]      m_tdata,
  output logic [MODE_W-1:0]     m_tuser
);

  localparam int ENTRIES = 2 * GATES;
  localparam int PROD_W  = VAL_W + RATE_W;
  localparam logic [VAL_W-1:0] GATES_W = VAL_W'(GATES);

  // configuration
  logic [RATE_W-1:0] decay_rate;
  logic [VAL_W-1:0]  level_min, level_max, level_init;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_rate <= DECAY_RATE_RST;
      level_min  <= LEVEL_MIN_RST;
      level_max  <= LEVEL_MAX_RST;
      level_init <= LEVEL_INIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_DECAY_RATE: decay_rate <= cfg_data[RATE_W-1:0];
        CFG_LEVEL_MIN:  level_min  <= cfg_data;
        CFG_LEVEL_MAX:  level_max  <= cfg_data;
        CFG_LEVEL_INIT: level_init <= cfg_data;
      endcase
    end
  end

  // item fields
  logic [MODE_W-1:0] item_mode;
  logic [7:0]        item_gate;
  logic              item_choice;
  logic [7:0]        item_weight;
  logic [VAL_W-1:0]  item_score;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode   <= s_mode;
      item_gate   <= s_tdata[7:0];
      item_choice <= s_tdata[8];
      item_weight <= s_tdata[16:9];
      item_score  <= s_tdata[48:17];
    end
  end

  logic              gate_ok;
  logic [AW+8:0]     idx_wide;
  logic [AW-1:0]     dep_addr, rd_addr;

  assign gate_ok  = ({24'b0, item_gate} < GATES_W);
  assign idx_wide = {{AW{1'b0}}, item_gate, item_choice};
  assign dep_addr = idx_wide[AW-1:0];
  assign rd_addr  = cmd.sweep ? sweep_addr : dep_addr;

  // table memory
  logic [VAL_W-1:0] mem [ENTRIES];
  logic [VAL_W-1:0] rdata;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rdata <= mem[rd_addr];
  end

  // sweep pipeline: read, multiply, write back
  logic              s1_valid, s2_valid;
  logic [AW-1:0]     s1_addr, s2_addr;
  logic [VAL_W-1:0]  s2_p;
  logic [PROD_W-1:0] s2_prod;
  logic [VAL_W-1:0]  sweep_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en & cmd.sweep;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= rd_addr;
    s2_addr <= s1_addr;
    s2_p    <= rdata;
    s2_prod <= PROD_W'(rdata) * PROD_W'(decay_rate);
  end

  always_comb begin
    case (item_mode)
      MODE_INIT:  sweep_val = level_init;
      MODE_EVAP:  sweep_val = s2_p - s2_prod[PROD_W-1:RATE_W];
      MODE_CLAMP: begin
        if (s2_p < level_min)      sweep_val = level_min;
        else if (s2_p > level_max) sweep_val = level_max;
        else                       sweep_val = s2_p;
      end
      default:    sweep_val = s2_p;
    endcase
  end

  // restoring divider: (weight << 32) / score, quotient saturates when weight >= score
  logic [VAL_W-1:0] rem, quo;
  logic             div_sat;
  logic [VAL_W:0]   trial, diff;
  logic             fits;

  assign trial = {rem, 1'b0};
  assign diff  = trial - {1'b0, item_score};
  assign fits  = (trial >= {1'b0, item_score});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem     <= {24'b0, item_weight};
      quo     <= '0;
      div_sat <= ({24'b0, item_weight} >= item_score);
    end else if (cmd.div_step) begin
      rem <= fits ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      quo <= {quo[VAL_W-2:0], fits};
    end
  end

  logic [VAL_W-1:0] val, dep_amt, dep_sum;
  logic [VAL_W:0]   sum_wide;

  assign dep_amt  = div_sat ? '1 : quo;
  assign sum_wide = {1'b0, val} + {1'b0, dep_amt};
  assign dep_sum  = sum_wide[VAL_W] ? '1 : sum_wide[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.cap_p)       val <= rdata;
    else if (cmd.dep_wr) val <= dep_sum;
  end

  assign mem_we    = s2_valid | cmd.dep_wr;
  assign mem_waddr = s2_valid ? s2_addr : dep_addr;
  assign mem_wdata = s2_valid ? sweep_val : dep_sum;

  // result register
  logic [VAL_W-1:0] res_val;

  assign res_val = ((item_mode == MODE_DEPOSIT || item_mode == MODE_READ) && gate_ok)
                   ? val : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      m_tdata <= res_val;
      m_tuser <= item_mode;
    end
  end

  assign sts.pipe_busy = s1_valid | s2_valid;
  assign sts.gate_ok   = gate_ok;
  assign sts.out_busy  = m_tvalid & ~m_tready;

  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    !(s2_valid && cmd.dep_wr))
    else $error("sweep write collides with deposit write");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

/* verif/pte_checker.sv */
`timescale 1ns / 1ps
module pte_checker
  import pte_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [VAL_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // gate[7:0], choice[8], weight[16:9], score[48:17]
  input  logic [MODE_W-1:0]     s_tuser,  // mode[2:0]
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [VAL_W-1:0]      m_tdata,  // value[31:0]
  input  logic [MODE_W-1:0]     m_tuser,  // op_done[2:0]
  output int                    n_errors,
  output int                    n_pending,
  output int                    n_checked
);

  localparam int ENTRIES = 2 * GATES_DEF;
  localparam logic [VAL_W-1:0] Q_ALL = '1;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [MODE_W-1:0] op_done;
  } pte_result_t;

  logic [RATE_W-1:0] decay_rate;
  logic [VAL_W-1:0]  level_min;
  logic [VAL_W-1:0]  level_max;
  logic [VAL_W-1:0]  level_init;
  logic [VAL_W-1:0]  level_tbl [ENTRIES];
  pte_result_t       result_q [$];
  int                err_cnt = 0;
  int                chk_cnt = 0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // weight * 2^32 / score, saturated; zero score gives all ones like the divider
  function automatic logic [VAL_W-1:0] deposit_amount(input logic [7:0] weight,
                                                      input logic [VAL_W-1:0] score);
    logic [63:0] quot;
    if (score == '0) return Q_ALL;
    quot = {24'd0, weight, 32'd0} / {32'd0, score};
    return (quot[63:32] != '0) ? Q_ALL : quot[VAL_W-1:0];
  endfunction

  // Runs one operation on the shadow table; returns 1 when it yields a result.
  function automatic bit update_table(input logic [MODE_W-1:0] mode,
                                      input logic [7:0]        gate,
                                      input logic              choice,
                                      input logic [7:0]        weight,
                                      input logic [VAL_W-1:0]  score,
                                      output pte_result_t      res);
    logic [47:0]    prod;
    logic [VAL_W:0] sum;
    int             idx;
    int             i;
    bit             gate_ok;
    gate_ok     = int'(gate) < GATES_DEF;
    idx         = gate_ok ? int'(gate) * 2 + int'(choice) : 0;
    res.value   = '0;
    res.op_done = mode;
    case (mode)
      MODE_INIT: begin
        for (i = 0; i < ENTRIES; i++) level_tbl[i] = level_init;
      end
      MODE_EVAP: begin
        for (i = 0; i < ENTRIES; i++) begin
          prod = 48'(level_tbl[i]) * 48'(decay_rate);
          level_tbl[i] = level_tbl[i] - prod[47:16];
        end
      end
      MODE_CLAMP: begin
        // lower test first, so crossed limits resolve the same way as the RTL
        for (i = 0; i < ENTRIES; i++) begin
          if (level_tbl[i] < level_min) level_tbl[i] = level_min;
          else if (level_tbl[i] > level_max) level_tbl[i] = level_max;
        end
      end
      MODE_DEPOSIT: begin
        if (gate_ok) begin
          sum = {1'b0, level_tbl[idx]} + {1'b0, deposit_amount(weight, score)};
          level_tbl[idx] = sum[VAL_W] ? Q_ALL : sum[VAL_W-1:0];
          res.value = level_tbl[idx];
        end
      end
      MODE_READ: begin
        if (gate_ok) res.value = level_tbl[idx];
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    pte_result_t got;
    pte_result_t want;
    pte_result_t res;
    if (rst) begin
      decay_rate = DECAY_RATE_RST;
      level_min  = LEVEL_MIN_RST;
      level_max  = LEVEL_MAX_RST;
      level_init = LEVEL_INIT_RST;
      result_q.delete();
    end else begin
      // results always belong to earlier transactions, so pop before push
      if (m_tvalid && m_tready) begin
        got.value   = m_tdata;
        got.op_done = m_tuser;
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%h op_done=%0d",
                                    got.value, got.op_done));
        end else begin
          want = result_q.pop_front();
          chk_cnt++;
          if (got.op_done !== want.op_done)
            report_mismatch($sformatf("op_done %0d, wanted %0d", got.op_done, want.op_done));
          if (got.value !== want.value)
            report_mismatch($sformatf("value %h, wanted %h (op %0d)",
                                      got.value, want.value, want.op_done));
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_DECAY_RATE: decay_rate = cfg_data[RATE_W-1:0];
          CFG_LEVEL_MIN:  level_min  = cfg_data;
          CFG_LEVEL_MAX:  level_max  = cfg_data;
          CFG_LEVEL_INIT: level_init = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        if (update_table(s_tuser, s_tdata[7:0], s_tdata[8], s_tdata[16:9], s_tdata[48:17], res))
          result_q.push_back(res);
      end
    end
    n_errors  <= err_cnt;
    n_pending <= result_q.size();
    n_checked <= chk_cnt;
  end

endmodule

/* verif/tb_pheromone_table_engine.sv */
`timescale 1ns / 1ps
module tb_pheromone_table_engine;
  import pte_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [VAL_W-1:0]  Q_ALL        = '1;
  localparam logic [VAL_W-1:0]  Q_ONE        = 32'h0001_0000;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 600;  // covers a full table sweep
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 205;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [VAL_W-1:0]      cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;  // gate[7:0], choice[8], weight[16:9], score[48:17]
  logic [MODE_W-1:0]     s_tuser  = '0;  // mode[2:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [VAL_W-1:0]      m_tdata;        // value[31:0]
  logic [MODE_W-1:0]     m_tuser;        // op_done[2:0]

  int n_errors;
  int n_pending;
  int n_checked;
  int mode_cnt [8];
  int idle_cycles = 0;
  int settings    = 0;
  bit no_idle     = 1'b0;

  always #2 clk = ~clk;

  pheromone_table_engine i_dut (
    .clk, .rst, .cfg_we, .cfg_addr, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  pte_checker i_chk (.*);

  // sender: called at a falling edge, returns at the falling edge after the transaction
  task automatic send_op(input logic [MODE_W-1:0] mode, input logic [7:0] gate,
                         input logic choice, input logic [7:0] weight,
                         input logic [VAL_W-1:0] score);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = mode;
    s_tdata  = {7'd0, score, weight, choice, gate};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    mode_cnt[mode]++;
  endtask

  // wait for every result, then let any result-less transaction finish
  task automatic quiesce();
    s_tvalid = 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [RATE_W-1:0] rate, input logic [VAL_W-1:0] lo,
                            input logic [VAL_W-1:0] hi, input logic [VAL_W-1:0] init_lvl);
    cfg_we   = 1'b1;
    cfg_addr = CFG_DECAY_RATE;
    cfg_data = {16'd0, rate};
    @(negedge clk);
    cfg_addr = CFG_LEVEL_MIN;
    cfg_data = lo;
    @(negedge clk);
    cfg_addr = CFG_LEVEL_MAX;
    cfg_data = hi;
    @(negedge clk);
    cfg_addr = CFG_LEVEL_INIT;
    cfg_data = init_lvl;
    @(negedge clk);
    cfg_we = 1'b0;
    settings++;
  endtask

  task automatic send_random();
    int                pick;
    logic [MODE_W-1:0] mode;
    logic [7:0]        gate;
    logic [7:0]        weight;
    logic [VAL_W-1:0]  score;
    pick = $urandom_range(0, 99);
    if (pick < 4)       mode = MODE_INIT;
    else if (pick < 18) mode = MODE_EVAP;
    else if (pick < 28) mode = MODE_CLAMP;
    else if (pick < 65) mode = MODE_DEPOSIT;
    else if (pick < 95) mode = MODE_READ;
    else if (pick < 97) mode = MODE_SPARE_5;
    else if (pick < 99) mode = MODE_SPARE_6;
    else                mode = MODE_SPARE_7;
    // a few hot gates so deposits pile up and saturate
    pick = $urandom_range(0, 9);
    if (pick < 3)       gate = 8'($urandom_range(0, 3));
    else if (pick == 3) gate = 8'hFF;
    else                gate = 8'($urandom_range(0, 255));
    weight = ($urandom_range(0, 4) == 0) ? 8'd1 : 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 4)       score = $urandom;
    else if (pick < 7)  score = $urandom_range(1, 32'h0002_0000);
    else if (pick == 7) score = 32'd1 << $urandom_range(0, 31);
    else if (pick == 8) score = $urandom_range(32'hFFFF_0000, 32'hFFFF_FFFF);
    else                score = $urandom_range(0, 3);
    send_op(mode, gate, 1'($urandom), weight, score);
  endtask

  // receiver: holds off some results at random once they are offered
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready = 1'b0;
        @(negedge clk);
        while (!m_tvalid) @(negedge clk);
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               idle_cycles, n_pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    logic [VAL_W-1:0]  lo;
    logic [VAL_W-1:0]  hi;
    logic [VAL_W-1:0]  tmp;
    logic [RATE_W-1:0] rate;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // reset settings: fill, odd deposits, sweeps
    send_op(MODE_SPARE_5, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_INIT, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'hFF, 1'b1, 8'hFF, Q_ALL);
    send_op(MODE_DEPOSIT, 8'd0, 1'b0, 8'd1, Q_ONE);
    send_op(MODE_DEPOSIT, 8'hFF, 1'b1, 8'hFF, 32'd1);     // quotient overflows
    send_op(MODE_DEPOSIT, 8'd17, 1'b1, 8'd0, Q_ALL);      // zero weight
    send_op(MODE_DEPOSIT, 8'd18, 1'b0, 8'd7, 32'd0);      // zero score
    send_op(MODE_DEPOSIT, 8'd0, 1'b0, 8'hFF, Q_ALL);
    send_op(MODE_EVAP, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'hFF, 1'b1, 8'd0, 32'd1);
    send_op(MODE_CLAMP, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd18, 1'b0, 8'd0, 32'd1);
    send_op(MODE_SPARE_6, 8'hFF, 1'b1, 8'hFF, Q_ALL);
    send_op(MODE_SPARE_7, 8'd0, 1'b0, 8'd0, 32'd0);
    quiesce();

    // full decay, top init, crossed limits
    set_config(16'hFFFF, 32'h0003_0000, Q_ONE, Q_ALL);
    send_op(MODE_INIT, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_DEPOSIT, 8'd1, 1'b0, 8'd1, 32'h0002_0000);  // already at the top
    send_op(MODE_EVAP, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd1, 1'b1, 8'd0, 32'd1);
    send_op(MODE_DEPOSIT, 8'd2, 1'b1, 8'd200, Q_ONE);
    send_op(MODE_CLAMP, 8'd0, 1'b0, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd2, 1'b1, 8'd0, 32'd1);
    send_op(MODE_READ, 8'd1, 1'b1, 8'd0, 32'd1);
    quiesce();

    for (int ph = 0; ph < PHASES; ph++) begin
      lo   = $urandom;
      hi   = $urandom;
      rate = 16'($urandom);
      case (ph)
        0: set_config(DECAY_RATE_RST, LEVEL_MIN_RST, LEVEL_MAX_RST, LEVEL_INIT_RST);
        1: set_config(16'd0, 32'd0, Q_ALL, 32'd0);
        2: set_config(16'hFFFF, Q_ALL, Q_ALL, Q_ALL);
        3: set_config(16'h8000, 32'h0000_8000, 32'h0004_0000, Q_ONE);
        4: begin
          if (lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          set_config(rate, lo, hi, $urandom);
        end
        5: begin
          if (lo < hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
          end
          set_config(rate, lo, hi, $urandom);
        end
        6: set_config(16'd1, 32'd0, 32'd0, 32'h1234_5678);
        default: set_config(rate, lo, hi, $urandom);
      endcase
      if ($urandom_range(0, 1) == 1) send_op(MODE_INIT, 8'd0, 1'b0, 8'd0, 32'd1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        no_idle = (ph == 2) || (ph == 5) || (k % 60 < 10);
        send_random();
      end
      no_idle = 1'b0;
      quiesce();
    end

    $display("sent %0d init, %0d evaporate, %0d clamp, %0d deposit, %0d read, %0d spare-mode",
             mode_cnt[MODE_INIT], mode_cnt[MODE_EVAP], mode_cnt[MODE_CLAMP],
             mode_cnt[MODE_DEPOSIT], mode_cnt[MODE_READ],
             mode_cnt[MODE_SPARE_5] + mode_cnt[MODE_SPARE_6] + mode_cnt[MODE_SPARE_7]);
    $display("%0d results compared across %0d register settings, %0d mismatches",
             n_checked, settings + 1, n_errors);
    if (n_errors == 0 && n_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* pheromone_table_engine.f */
design/pte_pkg.sv
design/pte_ctrl.sv
design/pte_dp.sv
design/pheromone_table_engine.sv
verif/pte_checker.sv
verif/tb_pheromone_table_engine.sv
